FILE: rtl/kwl_pkg.sv
package kwl_pkg;

    localparam int KW_COUNT   = 12;
    localparam int KW_MAX_LEN = 10;
    localparam int Q_DEPTH    = 4;

    localparam logic [7:0] TOK_NONE  = 8'h00;
    localparam logic [7:0] TOK_IDENT = "g";
    localparam logic [7:0] TOK_NUM   = "d";
    localparam logic [7:0] TOK_END   = "#";
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_DOT    = ".";

    // keyword text, left-justified, first character in the top byte
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"include", 24'h0},
        {"string", 32'h0},
        "iostream.h",
        {"if", 64'h0},
        {"while", 40'h0},
        {"void", 48'h0},
        {"int", 56'h0},
        {"main", 48'h0},
        {"cout", 48'h0},
        {"cin", 56'h0},
        {"for", 56'h0},
        {"else", 48'h0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd6, 4'd10, 4'd2, 4'd5, 4'd4, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd4
    };

    localparam logic [7:0] KW_CODE [KW_COUNT] = '{
        TOK_NONE, TOK_NONE, TOK_NONE, "i", "w", "v", "t", "m",
        TOK_NONE, TOK_NONE, TOK_NONE, "e"
    };

    // one or two tokens caused by one input item
    typedef struct packed {
        logic       two;
        logic [7:0] tok0;
        logic [7:0] tok1;
    } kwl_entry_t;

endpackage

FILE: rtl/kwl_front.sv
module kwl_front #(
    parameter int WORD_CHARS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_in,
    input  logic                s_end_of_source,
    input  logic                q_full,
    output logic                q_push,
    output kwl_pkg::kwl_entry_t q_data
);
    import kwl_pkg::*;

    localparam int LEN_W = $clog2(WORD_CHARS + 1);
    localparam int IDX_W = $clog2(WORD_CHARS);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       store_reg [WORD_CHARS];

    logic                fire;
    logic                is_letter, is_digit, is_dot, is_space;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [KW_MAX_LEN*8-1:0] word_vec;
    logic                kw_hit;
    logic [7:0]          kw_code;
    logic                f_valid, c_valid;
    logic [7:0]          f_code, c_code;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;

    assign is_letter = (s_char_in >= "a" && s_char_in <= "z") ||
                       (s_char_in >= "A" && s_char_in <= "Z");
    assign is_digit  = (s_char_in >= "0" && s_char_in <= "9");
    assign is_dot    = (s_char_in == CH_DOT);
    assign is_space  = (s_char_in == CH_SPACE) || (s_char_in == CH_LF);

    always_comb begin
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            word_vec[(KW_MAX_LEN-1-j)*8 +: 8] = store_reg[j];
        end
    end

    // parallel keyword compare over the kept characters
    always_comb begin
        logic [KW_MAX_LEN*8-1:0] mask;
        kw_hit  = 1'b0;
        kw_code = TOK_NONE;
        mask    = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                mask[(KW_MAX_LEN-1-j)*8 +: 8] = (j < int'(KW_LEN[k])) ? 8'hff : 8'h00;
            end
            if ((len_reg == LEN_W'(KW_LEN[k])) &&
                (((word_vec ^ KW_TEXT[k]) & mask) == '0)) begin
                kw_hit  = 1'b1;
                kw_code = KW_CODE[k];
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        wr_en     = 1'b0;
        wr_idx    = '0;
        f_valid   = 1'b0;
        f_code    = TOK_IDENT;
        c_valid   = 1'b0;
        c_code    = s_char_in;
        if (s_end_of_source ||
            !((mode_reg == MODE_WORD && (is_letter || is_digit || is_dot)) ||
              (mode_reg == MODE_NUMBER && (is_digit || is_dot)))) begin
            // pending token ends here
            unique case (mode_reg)
                MODE_WORD: begin
                    f_valid = !kw_hit || (kw_code != TOK_NONE);
                    f_code  = kw_hit ? kw_code : TOK_IDENT;
                end
                MODE_NUMBER: begin
                    f_valid = 1'b1;
                    f_code  = TOK_NUM;
                end
                default: ;
            endcase
            mode_next = MODE_IDLE;
            len_next  = '0;
            if (s_end_of_source) begin
                c_valid = 1'b1;
                c_code  = TOK_END;
            end else if (is_space) begin
                c_valid = 1'b0;
            end else if (is_letter) begin
                mode_next = MODE_WORD;
                len_next  = LEN_W'(1);
                wr_en     = 1'b1;
            end else if (is_digit) begin
                mode_next = MODE_NUMBER;
            end else begin
                c_valid = 1'b1;
            end
        end else if (mode_reg == MODE_WORD && len_reg < LEN_W'(WORD_CHARS)) begin
            wr_en    = 1'b1;
            wr_idx   = len_reg[IDX_W-1:0];
            len_next = len_reg + LEN_W'(1);
        end
    end

    assign q_push      = fire && (f_valid || c_valid);
    assign q_data.two  = f_valid && c_valid;
    assign q_data.tok0 = f_valid ? f_code : c_code;
    assign q_data.tok1 = c_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            if (wr_en) begin
                store_reg[wr_idx] <= s_char_in;
            end
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(WORD_CHARS))
        else $error("word length past limit");

    a_word_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_WORD) |-> (len_reg != '0))
        else $error("word mode with empty word");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_end_of_source) |=> (mode_reg == MODE_IDLE && len_reg == '0))
        else $error("not idle after end of source");
`endif

endmodule

FILE: rtl/kwl_queue.sv
module kwl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kwl_pkg::kwl_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output kwl_pkg::kwl_entry_t rd_data
);
    import kwl_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    kwl_entry_t       mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
`endif

endmodule

FILE: rtl/kwl_back.sv
module kwl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  kwl_pkg::kwl_entry_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_token_code,
    output logic                m_last_of_run
);
    import kwl_pkg::*;

    logic       out_valid_reg, out_last_reg, pend_valid_reg;
    logic [7:0] out_code_reg, pend_code_reg;
    logic       load;

    assign load  = !out_valid_reg || m_ready;
    assign q_pop = load && !pend_valid_reg && q_valid;

    assign m_valid       = out_valid_reg;
    assign m_token_code  = out_code_reg;
    assign m_last_of_run = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (load) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_code_reg   <= pend_code_reg;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (q_valid) begin
                out_valid_reg  <= 1'b1;
                out_code_reg   <= q_data.tok0;
                out_last_reg   <= !q_data.two;
                pend_valid_reg <= q_data.two;
                pend_code_reg  <= q_data.tok1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("second token without first on output");
`endif

endmodule

FILE: rtl/keyword_lexer_token_coder_unit.sv
// Streaming lexer: source bytes in, one-byte token codes out.
// Input channel s_*: one character per item in s_char_in; s_end_of_source
// high ends the text (s_char_in ignored), flushing the pending token and
// giving '#'. Output channel m_*: one token code per item, m_last_of_run
// high on the final token caused by an input item. Characters that only
// extend a word or number, and blanks, cause no output item.
// Throughput: one input item per cycle. An item that causes two tokens
// occupies the output register for both tokens in turn; a four-entry queue
// between the classifier and the output stage absorbs these, so s_ready
// drops only when the queue is full.
// The first token of an input item passes through the queue and then the
// output register before it appears on m_valid.
// Reset (aresetn low, synchronous): scanner idle, queue empty, m_valid low.
// When m_ready is low the output item holds; the queue fills and then
// s_ready falls until the receiver takes items again.
module keyword_lexer_token_coder_unit #(
    parameter int WORD_CHARS = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_source,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_token_code,
    output logic       m_last_of_run
);
    import kwl_pkg::*;

    logic       q_full, q_push, q_pop, q_valid;
    kwl_entry_t q_wdata, q_rdata;

    kwl_front #(
        .WORD_CHARS(WORD_CHARS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_source(s_end_of_source),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    kwl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    kwl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_code (m_token_code),
        .m_last_of_run(m_last_of_run)
    );

endmodule
